[rtl/kdv_pkg.sv]
// Shared types, op codes and saturation helpers for the distance/velocity tracker.
package kdv_pkg;

  localparam int PW = 128;   // raw product width
  localparam int WW = 160;   // product after an exact left shift

  typedef logic [1:0]         op_t;
  typedef logic signed [31:0] fix_t;
  typedef logic signed [47:0] cov_t;
  typedef logic signed [63:0] wide_t;

  localparam op_t OP_INIT    = 2'd0;
  localparam op_t OP_PREDICT = 2'd1;
  localparam op_t OP_DUPD    = 2'd2;
  localparam op_t OP_VUPD    = 2'd3;

  localparam logic [1:0] CFG_ACCEL = 2'd0;
  localparam logic [1:0] CFG_DIST  = 2'd1;
  localparam logic [1:0] CFG_VEL   = 2'd2;

  // clamp a signed value to w bits (w is 32 or 48)
  function automatic wide_t sat_s(wide_t x, int w);
    wide_t hi;
    wide_t lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // sign and magnitude to a signed word clamped to 48 or 60 bits
  function automatic wide_t sat_mag(logic [WW-1:0] m, logic neg, logic w48);
    logic [WW-1:0] lim;
    logic [WW-1:0] mg;
    lim = w48 ? (WW'(1) << 47) : (WW'(1) << 59);
    if (neg) begin
      mg = (m > lim) ? lim : m;
      return -wide_t'(mg[63:0]);
    end
    mg = (m > lim - WW'(1)) ? lim - WW'(1) : m;
    return wide_t'(mg[63:0]);
  endfunction

endpackage

[rtl/kdv_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface kdv_in_if import kdv_pkg::*; ();
  logic        valid;
  logic        ready;
  op_t         op;
  fix_t        distance_in;
  fix_t        velocity_in;
  fix_t        accel_in;
  logic [16:0] step_time;
  modport source (output valid, op, distance_in, velocity_in, accel_in, step_time,
                  input ready);
  modport sink (input valid, op, distance_in, velocity_in, accel_in, step_time,
                output ready);
endinterface

interface kdv_out_if import kdv_pkg::*; ();
  logic valid;
  logic ready;
  fix_t distance_est;
  fix_t velocity_est;
  logic update_skipped;
  modport source (output valid, distance_est, velocity_est, update_skipped, input ready);
  modport sink (input valid, distance_est, velocity_est, update_skipped, output ready);
endinterface

[rtl/kalman_distance_velocity_2state_top.sv]
// Two-state distance/velocity Kalman tracker on one shared multiplier and divider.
// Sequences: init commits the measurement directly; predict runs 12 multiplies, then commits;
//   update runs 7 multiplies and two divides, then commits; a skipped update stops after its first
//   multiply. Every commit waits for the output register to be free. The multiplier is 64x16 (4 digit
//   steps) and the divider is a one-bit-per-cycle restoring divider.
// A new item is taken only when the sequencer is idle; items are processed one at a time.
// Reset (sync, active low): state zero, covariance diagonal one, noise registers to defaults.
module kalman_distance_velocity_2state_top
  import kdv_pkg::*;
#(
  parameter int FRAC_BITS     = 16,
  parameter int COV_FRAC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  kdv_in_if.sink      in_ch,
  kdv_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int C    = COV_FRAC_BITS;
  localparam int NUMW = 49 + C;            // divider numerator width
  localparam int CNTW = $clog2(NUMW + 2);
  localparam int REMW = 50;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  localparam logic [1:0] K_MUL = 2'd0;
  localparam logic [1:0] K_DIV = 2'd1;
  localparam logic [1:0] K_ALU = 2'd2;

  // program counter: predict sequence, update sequence, init commit
  localparam logic [4:0] PC_PRED    = 5'd0;
  localparam logic [4:0] PC_PABC    = 5'd11;
  localparam logic [4:0] PC_PM3     = 5'd12;
  localparam logic [4:0] PC_PCOMMIT = 5'd13;
  localparam logic [4:0] PC_UPD     = 5'd16;
  localparam logic [4:0] PC_USUM    = 5'd17;
  localparam logic [4:0] PC_UDIV0   = 5'd18;
  localparam logic [4:0] PC_UDIV1   = 5'd19;
  localparam logic [4:0] PC_UCOMMIT = 5'd26;
  localparam logic [4:0] PC_INIT    = 5'd30;

  // scratch slots, predict
  localparam logic [3:0] T_VDT = 4'd0,  T_ADT = 4'd1,  T_H   = 4'd2,  T_DT2 = 4'd3;
  localparam logic [3:0] T_DT3 = 4'd4,  T_DT4 = 4'd5,  T_Q4  = 4'd6,  T_H3  = 4'd7;
  localparam logic [3:0] T_Q2  = 4'd8,  T_M1  = 4'd9,  T_M2  = 4'd10, T_TA  = 4'd11;
  localparam logic [3:0] T_TB  = 4'd12, T_N10 = 4'd13, T_M3  = 4'd14;
  // scratch slots, update
  localparam logic [3:0] T_RC  = 4'd0,  T_Y   = 4'd1,  T_K0  = 4'd2,  T_K1  = 4'd3;
  localparam logic [3:0] T_X0  = 4'd4,  T_X1  = 4'd5,  T_U00 = 4'd6,  T_U01 = 4'd7;
  localparam logic [3:0] T_U10 = 4'd8,  T_U11 = 4'd9;

  localparam logic signed [7:0] SH_F    = 8'(F);
  localparam logic signed [7:0] SH_F1   = 8'(F + 1);
  localparam logic signed [7:0] SH_Q4   = 8'(2 * F - C + 2);
  localparam logic signed [7:0] SH_H3   = 8'(2 * F - C + 1);
  localparam logic signed [7:0] SH_Q2   = 8'(2 * F - C);
  localparam logic signed [7:0] SH_R    = 8'(F - C);
  localparam logic signed [7:0] SH_C    = 8'(C);

  logic            state_r;
  logic [4:0]      pc_r;
  logic [CNTW-1:0] cnt_r;
  op_t             op_r;
  fix_t            zd_r, zv_r, accel_r;
  logic [16:0]     dt_r;
  logic [30:0]     qa_r, rd_r, rv_r;
  fix_t            d_r, v_r;
  cov_t            p00_r, p01_r, p10_r, p11_r;
  wide_t           t_r [16];
  logic signed [49:0] s_r;
  logic [63:0]     ma_r, mb_r;
  logic [PW-1:0]   prod_r;
  logic            neg_r;
  logic [NUMW-1:0] num_r, quo_r;
  logic [REMW-1:0] rem_r, dm_r;
  logic            out_valid_r, skip_r;
  fix_t            out_d_r, out_v_r;

  // update selectors: distance update works on element 0, velocity on element 1
  logic  sel;
  cov_t  pss, p0s, p1s, ps0, ps1;
  fix_t  xs, zs;
  logic [30:0] rs;
  assign sel = (op_r == OP_VUPD);
  assign pss = sel ? p11_r : p00_r;
  assign p0s = sel ? p01_r : p00_r;
  assign p1s = sel ? p11_r : p10_r;
  assign ps0 = sel ? p10_r : p00_r;
  assign ps1 = sel ? p11_r : p01_r;
  assign xs  = sel ? v_r : d_r;
  assign zs  = sel ? zv_r : zd_r;
  assign rs  = sel ? rv_r : rd_r;

  wide_t dt_w;
  assign dt_w = wide_t'({47'd0, dt_r});

  // micro-op decode
  logic [1:0]        kind;
  wide_t             mul_a, mul_b;
  logic signed [7:0] mul_sh;
  logic              mul_w48;
  logic [3:0]        dst;
  cov_t              div_n;

  always_comb begin
    kind    = K_MUL;
    mul_a   = '0;
    mul_b   = dt_w;
    mul_sh  = SH_F;
    mul_w48 = 1'b0;
    dst     = '0;
    div_n   = p0s;
    case (pc_r)
      5'd0:  begin mul_a = wide_t'(v_r);     dst = T_VDT; end
      5'd1:  begin mul_a = wide_t'(accel_r); dst = T_ADT; end
      5'd2:  begin mul_a = t_r[T_ADT]; mul_sh = SH_F1; dst = T_H; end
      5'd3:  begin mul_a = dt_w;       dst = T_DT2; end
      5'd4:  begin mul_a = t_r[T_DT2]; dst = T_DT3; end
      5'd5:  begin mul_a = t_r[T_DT2]; mul_b = t_r[T_DT2]; dst = T_DT4; end
      5'd6:  begin
        mul_a = wide_t'({33'd0, qa_r}); mul_b = t_r[T_DT4];
        mul_sh = SH_Q4; mul_w48 = 1'b1; dst = T_Q4;
      end
      5'd7:  begin
        mul_a = wide_t'({33'd0, qa_r}); mul_b = t_r[T_DT3];
        mul_sh = SH_H3; mul_w48 = 1'b1; dst = T_H3;
      end
      5'd8:  begin
        mul_a = wide_t'({33'd0, qa_r}); mul_b = t_r[T_DT2];
        mul_sh = SH_Q2; mul_w48 = 1'b1; dst = T_Q2;
      end
      5'd9:  begin mul_a = wide_t'(p10_r); dst = T_M1; end
      5'd10: begin mul_a = wide_t'(p11_r); dst = T_M2; end
      PC_PM3: begin mul_a = t_r[T_TB]; dst = T_M3; end
      PC_UPD: begin
        mul_a = wide_t'({33'd0, rs}); mul_b = 64'sd1;
        mul_sh = SH_R; mul_w48 = 1'b1; dst = T_RC;
      end
      PC_UDIV0: begin kind = K_DIV; div_n = p0s; dst = T_K0; end
      PC_UDIV1: begin kind = K_DIV; div_n = p1s; dst = T_K1; end
      5'd20: begin mul_a = t_r[T_K0]; mul_b = t_r[T_Y]; mul_sh = SH_C; dst = T_X0; end
      5'd21: begin mul_a = t_r[T_K1]; mul_b = t_r[T_Y]; mul_sh = SH_C; dst = T_X1; end
      5'd22: begin
        mul_a = t_r[T_K0]; mul_b = wide_t'(ps0); mul_sh = SH_C; dst = T_U00;
      end
      5'd23: begin
        mul_a = t_r[T_K0]; mul_b = wide_t'(ps1); mul_sh = SH_C; dst = T_U01;
      end
      5'd24: begin
        mul_a = t_r[T_K1]; mul_b = wide_t'(ps0); mul_sh = SH_C; dst = T_U10;
      end
      5'd25: begin
        mul_a = t_r[T_K1]; mul_b = wide_t'(ps1); mul_sh = SH_C; dst = T_U11;
      end
      default: kind = K_ALU;
    endcase
  end

  // multiplier: rounding right shift or exact left shift, then clamp
  logic [7:0]    rsh, lsh;
  logic [WW-1:0] mul_wide;
  wide_t         mul_res, div_res;
  assign rsh = 8'(mul_sh);
  assign lsh = 8'(-mul_sh);
  always_comb begin
    if (mul_sh > 8'sd0)
      mul_wide = (WW'(prod_r) + (WW'(1) << (rsh - 8'd1))) >> rsh;
    else
      mul_wide = WW'(prod_r) << lsh;
  end
  assign mul_res = sat_mag(mul_wide, neg_r, mul_w48);
  assign div_res = sat_mag(WW'(quo_r), neg_r, 1'b1);

  // divider step
  logic [REMW-1:0] trial;
  assign trial = {rem_r[REMW-2:0], num_r[NUMW-1]};

  // innovation variance and innovation
  logic signed [49:0] s_sum;
  wide_t              innov;
  assign s_sum = 50'(pss) + 50'(t_r[T_RC]);
  assign innov = wide_t'(zs) - wide_t'(xs);

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  // a result is loaded into the output register this cycle
  logic res_load;
  assign res_load = (state_r == S_RUN) && (kind == K_ALU) && out_free &&
                    ((pc_r == PC_PCOMMIT) || (pc_r == PC_UCOMMIT) || (pc_r == PC_INIT) ||
                     ((pc_r == PC_USUM) && (s_sum == '0)));

  // commit values
  fix_t pd_n, pv_n, ud_n, uv_n;
  assign pd_n = 32'(sat_s(wide_t'(d_r) - t_r[T_VDT] - t_r[T_H], 32));
  assign pv_n = 32'(sat_s(wide_t'(v_r) + t_r[T_ADT], 32));
  assign ud_n = 32'(sat_s(wide_t'(d_r) + t_r[T_X0], 32));
  assign uv_n = 32'(sat_s(wide_t'(v_r) + t_r[T_X1], 32));

  wide_t mag_a, mag_b;
  wide_t div_mag;
  assign mag_a   = (mul_a < 0) ? -mul_a : mul_a;
  assign mag_b   = (mul_b < 0) ? -mul_b : mul_b;
  assign div_mag = (div_n < 0) ? -wide_t'(div_n) : wide_t'(div_n);

  logic [REMW-1:0] s_mag;
  assign s_mag = (s_r < 0) ? REMW'(-s_r) : REMW'(s_r);

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.distance_est   = out_d_r;
  assign out_ch.velocity_est   = out_v_r;
  assign out_ch.update_skipped = skip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= PC_PRED;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      qa_r        <= 31'd6554;
      rd_r        <= 31'd32768;
      rv_r        <= 31'd13107;
      d_r         <= '0;
      v_r         <= '0;
      p00_r       <= cov_t'(64'sd1 <<< C);
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= cov_t'(64'sd1 <<< C);
    end else begin
      if (out_valid_r && out_ch.ready && !res_load) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_ACCEL: qa_r <= cfg_data;
          CFG_DIST:  rd_r <= cfg_data;
          CFG_VEL:   rv_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.op;
            zd_r    <= in_ch.distance_in;
            zv_r    <= in_ch.velocity_in;
            accel_r <= in_ch.accel_in;
            dt_r    <= in_ch.step_time;
            cnt_r   <= '0;
            state_r <= S_RUN;
            case (in_ch.op)
              OP_INIT:    pc_r <= PC_INIT;
              OP_PREDICT: pc_r <= PC_PRED;
              default:    pc_r <= PC_UPD;
            endcase
          end
        end
        default: begin
          case (kind)
            K_MUL: begin
              if (cnt_r == '0) begin
                ma_r   <= mag_a;
                mb_r   <= mag_b;
                neg_r  <= (mul_a < 0) != (mul_b < 0);
                prod_r <= '0;
                cnt_r  <= cnt_r + CNTW'(1);
              end else if (cnt_r != CNTW'(5)) begin
                // high digit first: shift accumulated sum up one digit
                prod_r <= (prod_r << 16) + PW'({16'd0, ma_r} * {64'd0, mb_r[63:48]});
                mb_r   <= mb_r << 16;
                cnt_r  <= cnt_r + CNTW'(1);
              end else begin
                t_r[dst] <= mul_res;
                cnt_r    <= '0;
                pc_r     <= pc_r + 5'd1;
              end
            end
            K_DIV: begin
              if (cnt_r == '0) begin
                num_r <= (NUMW'(div_mag[47:0]) << C) + NUMW'(s_mag >> 1);
                dm_r  <= s_mag;
                neg_r <= (div_n < 0) != (s_r < 0);
                rem_r <= '0;
                quo_r <= '0;
                cnt_r <= cnt_r + CNTW'(1);
              end else if (cnt_r != CNTW'(NUMW + 1)) begin
                num_r <= num_r << 1;
                if (trial >= dm_r) begin
                  rem_r <= trial - dm_r;
                  quo_r <= {quo_r[NUMW-2:0], 1'b1};
                end else begin
                  rem_r <= trial;
                  quo_r <= {quo_r[NUMW-2:0], 1'b0};
                end
                cnt_r <= cnt_r + CNTW'(1);
              end else begin
                t_r[dst] <= div_res;
                cnt_r    <= '0;
                pc_r     <= pc_r + 5'd1;
              end
            end
            default: begin
              case (pc_r)
                PC_PABC: begin
                  t_r[T_TA]  <= sat_s(wide_t'(p00_r) - t_r[T_M1], 48);
                  t_r[T_TB]  <= sat_s(wide_t'(p01_r) - t_r[T_M2], 48);
                  t_r[T_N10] <= sat_s(wide_t'(p10_r) - t_r[T_M2] - t_r[T_H3], 48);
                  pc_r       <= PC_PM3;
                end
                PC_PCOMMIT: begin
                  if (out_free) begin
                    p00_r <= 48'(sat_s(t_r[T_TA] - t_r[T_M3] + t_r[T_Q4], 48));
                    p01_r <= 48'(sat_s(t_r[T_TB] - t_r[T_H3], 48));
                    p10_r <= 48'(t_r[T_N10]);
                    p11_r <= 48'(sat_s(wide_t'(p11_r) + t_r[T_Q2], 48));
                    d_r   <= pd_n;
                    v_r   <= pv_n;
                    out_d_r     <= pd_n;
                    out_v_r     <= pv_n;
                    skip_r      <= 1'b0;
                    out_valid_r <= 1'b1;
                    state_r     <= S_IDLE;
                  end
                end
                PC_USUM: begin
                  if (s_sum == '0) begin
                    // zero innovation variance: leave the filter as it is
                    if (out_free) begin
                      out_d_r     <= d_r;
                      out_v_r     <= v_r;
                      skip_r      <= 1'b1;
                      out_valid_r <= 1'b1;
                      state_r     <= S_IDLE;
                    end
                  end else begin
                    s_r      <= s_sum;
                    t_r[T_Y] <= innov;
                    pc_r     <= PC_UDIV0;
                  end
                end
                PC_UCOMMIT: begin
                  if (out_free) begin
                    p00_r <= 48'(sat_s(wide_t'(p00_r) - t_r[T_U00], 48));
                    p01_r <= 48'(sat_s(wide_t'(p01_r) - t_r[T_U01], 48));
                    p10_r <= 48'(sat_s(wide_t'(p10_r) - t_r[T_U10], 48));
                    p11_r <= 48'(sat_s(wide_t'(p11_r) - t_r[T_U11], 48));
                    d_r   <= ud_n;
                    v_r   <= uv_n;
                    out_d_r     <= ud_n;
                    out_v_r     <= uv_n;
                    skip_r      <= 1'b0;
                    out_valid_r <= 1'b1;
                    state_r     <= S_IDLE;
                  end
                end
                PC_INIT: begin
                  if (out_free) begin
                    d_r         <= zd_r;
                    v_r         <= zv_r;
                    out_d_r     <= zd_r;
                    out_v_r     <= zv_r;
                    skip_r      <= 1'b0;
                    out_valid_r <= 1'b1;
                    state_r     <= S_IDLE;
                  end
                end
                default: state_r <= S_IDLE;
              endcase
            end
          endcase
        end
      endcase
    end
  end

  // a skipped flag only ever comes from an update
  a_skip_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && skip_r |-> (op_r == OP_DUPD || op_r == OP_VUPD))
    else $error("skip flagged on init or predict");

  // init leaves the covariance alone
  a_init_cov: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && pc_r == PC_INIT |=> $stable(p00_r) && $stable(p11_r))
    else $error("init touched covariance");

  // multiplier digit counter never runs past its write cycle
  a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && kind == K_MUL |-> cnt_r <= CNTW'(5))
    else $error("multiplier counter overrun");

  // a divide only starts on a non-zero innovation variance
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && kind == K_DIV |-> s_r != '0)
    else $error("divide by zero variance");

  // a result only appears when the sequencer hands back to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> state_r == S_IDLE)
    else $error("result raised mid-sequence");

endmodule
